// ===== sv/amwsg_pkg.sv =====
// Package for the AM waveform sample generator: widths, fixed-point shifts,
// register indexes, the configuration struct and the quarter-wave cosine table.
// No dependencies; every other file of the block imports it.
package amwsg_pkg;

	// Sizing of the phase path and the sample table.
	localparam int PHASE_BITS      = 24;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_COUNT    = 199;

	// Field and register widths.
	localparam int INDEX_W    = 16;
	localparam int STEP_W     = 24;
	localparam int GAIN_W     = 16;
	localparam int CODE_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Index reduction by reciprocal multiplication.
	localparam int RECIP_W = 32;
	localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((64'd1 << RECIP_W) / SAMPLE_COUNT);
	localparam logic [INDEX_W:0] SAMPLE_COUNT_C = (INDEX_W+1)'(SAMPLE_COUNT);
	localparam int RAW_W = INDEX_W + 2;
	localparam logic [RAW_W-1:0] SAMPLE_COUNT_RAW = RAW_W'(SAMPLE_COUNT);

	// Cosine table, quarter wave, magnitudes 0..32767.
	localparam int COS_W        = 16;
	localparam int COS_MAG_W    = 15;
	localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
	localparam int QUARTER      = 1 << QUARTER_BITS;
	localparam logic [QUARTER_BITS:0] QUARTER_C = (QUARTER_BITS+1)'(QUARTER);

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SERIES_DIV [5] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};

	typedef logic [COS_MAG_W-1:0] cos_mag_table_t [QUARTER+1];

	// Evaluated at elaboration only: truncated Taylor series in Q30, rounded to Q15.
	function automatic cos_mag_table_t build_cos_table();
		cos_mag_table_t tbl;
		longint unsigned th;
		longint unsigned x2;
		longint unsigned t;
		longint c;
		longint v;
		int r;
		int i;
		for (r = 0; r <= QUARTER; r++) begin
			th = (longint'(r) * HALF_PI_Q30) >> QUARTER_BITS;
			x2 = (th * th) >> 30;
			t = ONE_Q30;
			for (i = 0; i < 5; i++) begin
				t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[i];
			end
			c = longint'(ONE_Q30) - longint'(((x2 * t) >> 30) / 2);
			if (c < 0) begin
				c = 0;
			end
			v = (c + 16384) >>> 15;
			if (v > 32767) begin
				v = 32767;
			end
			tbl[r] = COS_MAG_W'(v);
		end
		return tbl;
	endfunction

	localparam cos_mag_table_t COS_TABLE = build_cos_table();

	// Fixed-point datapath widths and shifts.
	localparam int PROD_W      = 32;
	localparam int MC_W        = 64;
	localparam int ONE_SHIFT   = 30;
	localparam int FLOOR_SHIFT = 20;
	localparam int HALF_SHIFT  = 25;
	localparam int DVD_SHIFT   = 26;
	localparam int DIVISOR_W   = GAIN_W + 1;
	localparam int NUM_W       = MC_W - FLOOR_SHIFT + 1;
	localparam int NUM_MAG_W   = NUM_W - 1;
	localparam int HALF_W      = NUM_MAG_W / 2;
	localparam int PP_W        = (NUM_MAG_W - HALF_W) + CODE_W;
	localparam int X_W         = NUM_MAG_W + CODE_W;
	localparam int DVD_W       = X_W - DVD_SHIFT;

	// Pipeline depth: phase stages, mixer stages, one divider stage per
	// quotient bit, and the output register.
	localparam int PHASE_STAGES = 5;
	localparam int MIX_STAGES   = 7;
	localparam int LATENCY      = PHASE_STAGES + MIX_STAGES + DVD_W + 1;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CARRIER_STEP    = 3'd0,
		REG_MODULATING_STEP = 3'd1,
		REG_CARRIER_GAIN    = 3'd2,
		REG_MODULATING_GAIN = 3'd3,
		REG_CODE_LOW        = 3'd4,
		REG_CODE_HIGH       = 3'd5
	} reg_idx_t;

	localparam logic [STEP_W-1:0] RST_CARRIER_STEP    = 24'd838861;
	localparam logic [STEP_W-1:0] RST_MODULATING_STEP = 24'd83886;
	localparam logic [GAIN_W-1:0] RST_CARRIER_GAIN    = 16'd32768;
	localparam logic [GAIN_W-1:0] RST_MODULATING_GAIN = 16'd29491;
	localparam logic [CODE_W-1:0] RST_CODE_LOW        = 16'd11873;
	localparam logic [CODE_W-1:0] RST_CODE_HIGH       = 16'd43253;

	typedef struct packed {
		logic [STEP_W-1:0] carrier_step;
		logic [STEP_W-1:0] modulating_step;
		logic [GAIN_W-1:0] carrier_gain;
		logic [GAIN_W-1:0] modulating_gain;
		logic [CODE_W-1:0] code_low;
		logic [CODE_W-1:0] code_high;
	} cfg_t;

endpackage

// ===== sv/amwsg_cfg_regs.sv =====
// Configuration register file of the AM waveform sample generator.
// Depends on amwsg_pkg for the register indexes, reset values and cfg_t.
module amwsg_cfg_regs import amwsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_step    <= RST_CARRIER_STEP;
			cfg_q.modulating_step <= RST_MODULATING_STEP;
			cfg_q.carrier_gain    <= RST_CARRIER_GAIN;
			cfg_q.modulating_gain <= RST_MODULATING_GAIN;
			cfg_q.code_low        <= RST_CODE_LOW;
			cfg_q.code_high       <= RST_CODE_HIGH;
		end else if (we) begin
			unique case (reg_idx_t'(index))
				REG_CARRIER_STEP:    cfg_q.carrier_step    <= data[STEP_W-1:0];
				REG_MODULATING_STEP: cfg_q.modulating_step <= data[STEP_W-1:0];
				REG_CARRIER_GAIN:    cfg_q.carrier_gain    <= data[GAIN_W-1:0];
				REG_MODULATING_GAIN: cfg_q.modulating_gain <= data[GAIN_W-1:0];
				REG_CODE_LOW:        cfg_q.code_low        <= data[CODE_W-1:0];
				REG_CODE_HIGH:       cfg_q.code_high       <= data[CODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/amwsg_phase.sv =====
// Phase front end: index reduction modulo the sample count, the two phase
// products and the cosine table lookups. Five register stages; uses amwsg_pkg.
module amwsg_phase import amwsg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_vld,
	input  logic [INDEX_W-1:0]      sample_index,
	output logic                    out_vld,
	output logic signed [COS_W-1:0] cos_c,
	output logic signed [COS_W-1:0] cos_m
);

	// Quarter-wave lookup: mirror the offset in odd quadrants, negate in the
	// second and third.
	function automatic logic signed [COS_W-1:0] cos_lookup(
		input logic [TABLE_ADDR_BITS-1:0] addr
	);
		logic [1:0]              quad;
		logic [QUARTER_BITS-1:0] off;
		logic [QUARTER_BITS:0]   idx;
		logic [COS_W-1:0]        mag;
		quad = addr[TABLE_ADDR_BITS-1 -: 2];
		off  = addr[QUARTER_BITS-1:0];
		idx  = quad[0] ? (QUARTER_C - {1'b0, off}) : {1'b0, off};
		mag  = {1'b0, COS_TABLE[idx]};
		return (quad[0] ^ quad[1]) ? -mag : mag;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [INDEX_W-1:0]         n_s1;
	logic [INDEX_W-1:0]         qe_s1;
	logic [RAW_W-1:0]           r_s2;
	logic [INDEX_W-1:0]         nm_s3;
	logic [PHASE_BITS-1:0]      ph_c_s4;
	logic [PHASE_BITS-1:0]      ph_m_s4;
	logic signed [COS_W-1:0]    cos_c_s5;
	logic signed [COS_W-1:0]    cos_m_s5;

	logic [INDEX_W+RECIP_W-1:0]             recip_prod;
	logic [2*INDEX_W:0]                     qsc;
	logic [RAW_W-1:0]                       r_raw;
	logic [RAW_W-1:0]                       r_fix;
	logic [INDEX_W+STEP_W-1:0]              prod_c;
	logic [INDEX_W+STEP_W-1:0]              prod_m;
	logic [PHASE_BITS+TABLE_ADDR_BITS-1:0]  pad_c;
	logic [PHASE_BITS+TABLE_ADDR_BITS-1:0]  pad_m;

	// The reciprocal estimate of the quotient is exact or one short.
	assign recip_prod = sample_index * RECIP_MUL;
	assign qsc        = qe_s1 * SAMPLE_COUNT_C;
	assign r_raw      = {2'b00, n_s1} - qsc[RAW_W-1:0];
	assign r_fix      = (r_s2 >= SAMPLE_COUNT_RAW) ? (r_s2 - SAMPLE_COUNT_RAW) : r_s2;
	assign prod_c     = nm_s3 * cfg.carrier_step;
	assign prod_m     = nm_s3 * cfg.modulating_step;
	// Padding with zeros takes the top address bits for any phase width.
	assign pad_c      = {ph_c_s4, {TABLE_ADDR_BITS{1'b0}}};
	assign pad_m      = {ph_m_s4, {TABLE_ADDR_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		n_s1     <= sample_index;
		qe_s1    <= recip_prod[INDEX_W+RECIP_W-1 -: INDEX_W];
		r_s2     <= r_raw;
		nm_s3    <= r_fix[INDEX_W-1:0];
		ph_c_s4  <= prod_c[PHASE_BITS-1:0];
		ph_m_s4  <= prod_m[PHASE_BITS-1:0];
		cos_c_s5 <= cos_lookup(pad_c[PHASE_BITS+TABLE_ADDR_BITS-1 -: TABLE_ADDR_BITS]);
		cos_m_s5 <= cos_lookup(pad_m[PHASE_BITS+TABLE_ADDR_BITS-1 -: TABLE_ADDR_BITS]);
	end

	assign out_vld = vld_s5;
	assign cos_c   = cos_c_s5;
	assign cos_m   = cos_m_s5;

endmodule

// ===== sv/amwsg_mix.sv =====
// Mixer: gain products, the AM product, offset and the scale by the code
// span, giving the sign and magnitude of the dividend. Seven stages; uses amwsg_pkg.
module amwsg_mix import amwsg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic [DIVISOR_W-1:0]    gain_sum,
	input  logic                    in_vld,
	input  logic signed [COS_W-1:0] cos_c,
	input  logic signed [COS_W-1:0] cos_m,
	output logic                    out_vld,
	output logic                    neg,
	output logic [DVD_W-1:0]        dvd
);

	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic signed [PROD_W-1:0] c_s6;
	logic signed [PROD_W-1:0] m_s6;
	logic signed [PROD_W-1:0] c_s7;
	logic signed [MC_W-1:0]   mc_s7;
	logic signed [MC_W-1:0]   p_s8;
	logic [NUM_W-1:0]         num_s9;
	logic [NUM_MAG_W-1:0]     mag_n_s10;
	logic [CODE_W-1:0]        mag_d_s10;
	logic                     neg_s10, neg_s11, neg_s12;
	logic [PP_W-1:0]          pl_s11;
	logic [PP_W-1:0]          ph_s11;
	logic [DVD_W-1:0]         dvd_s12;

	logic signed [GAIN_W:0]          cg_sgn;
	logic signed [GAIN_W:0]          mg_sgn;
	logic signed [GAIN_W+COS_W:0]    c_full;
	logic signed [GAIN_W+COS_W:0]    m_full;
	logic signed [MC_W-1:0]          mc_full;
	logic signed [MC_W-1:0]          c_sh;
	logic [NUM_W-1:0]                num;
	logic [NUM_W-1:0]                num_neg;
	logic [CODE_W:0]                 diff;
	logic [CODE_W:0]                 diff_neg;
	logic [X_W-1:0]                  x;

	assign cg_sgn  = $signed({1'b0, cfg.carrier_gain});
	assign mg_sgn  = $signed({1'b0, cfg.modulating_gain});
	assign c_full  = cg_sgn * cos_c;
	assign m_full  = mg_sgn * cos_m;
	assign mc_full = m_s6 * c_s6;
	// (1 + m) * c is formed as c shifted to Q60 plus m * c.
	assign c_sh    = {{(MC_W-PROD_W-ONE_SHIFT){c_s7[PROD_W-1]}}, c_s7, {ONE_SHIFT{1'b0}}};
	// Dropping the low bits of a two's complement value is a floor shift.
	assign num     = {p_s8[MC_W-1], p_s8[MC_W-1:FLOOR_SHIFT]}
	               + {{(NUM_W-DIVISOR_W-HALF_SHIFT){1'b0}}, gain_sum, {HALF_SHIFT{1'b0}}};
	assign num_neg = -num_s9;
	assign diff    = {1'b0, cfg.code_high} - {1'b0, cfg.code_low};
	assign diff_neg = -diff;
	assign x       = {ph_s11, {HALF_W{1'b0}}} + {{(X_W-PP_W){1'b0}}, pl_s11};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s6  <= in_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		c_s6      <= c_full[PROD_W-1:0];
		m_s6      <= m_full[PROD_W-1:0];
		c_s7      <= c_s6;
		mc_s7     <= mc_full;
		p_s8      <= c_sh + mc_s7;
		num_s9    <= num;
		mag_n_s10 <= num_s9[NUM_W-1] ? num_neg[NUM_MAG_W-1:0] : num_s9[NUM_MAG_W-1:0];
		mag_d_s10 <= diff[CODE_W] ? diff_neg[CODE_W-1:0] : diff[CODE_W-1:0];
		neg_s10   <= num_s9[NUM_W-1] ^ diff[CODE_W];
		pl_s11    <= mag_n_s10[HALF_W-1:0] * mag_d_s10;
		ph_s11    <= mag_n_s10[NUM_MAG_W-1:HALF_W] * mag_d_s10;
		neg_s11   <= neg_s10;
		dvd_s12   <= x[X_W-1:DVD_SHIFT];
		neg_s12   <= neg_s11;
	end

	assign out_vld = vld_s12;
	assign neg     = neg_s12;
	assign dvd     = dvd_s12;

endmodule

// ===== sv/amwsg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, dividing the
// magnitude by the total gain. Uses amwsg_pkg for the widths.
module amwsg_div import amwsg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DIVISOR_W-1:0] divisor,
	input  logic                 in_vld,
	input  logic                 in_neg,
	input  logic [DVD_W-1:0]     in_dvd,
	output logic                 out_vld,
	output logic                 out_neg,
	output logic [DVD_W-1:0]     quo
);

	// Each stage holds its partial remainder and a word in which dividend
	// bits shift out at the top while quotient bits shift in at the bottom.
	logic                 vld_s  [DVD_W];
	logic                 neg_s  [DVD_W];
	logic [DIVISOR_W-1:0] rem_s  [DVD_W];
	logic [DVD_W-1:0]     work_s [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_stage
		logic                 vld_in;
		logic                 neg_in;
		logic [DIVISOR_W-1:0] rem_in;
		logic [DVD_W-1:0]     work_in;
		logic [DIVISOR_W:0]   trial;
		logic [DIVISOR_W:0]   diff;
		logic                 fits;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign neg_in  = in_neg;
			assign rem_in  = '0;
			assign work_in = in_dvd;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign neg_in  = neg_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
		end

		assign trial = {rem_in, work_in[DVD_W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign fits  = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			neg_s[k]  <= neg_in;
			rem_s[k]  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			work_s[k] <= {work_in[DVD_W-2:0], fits};
		end
	end

	assign out_vld = vld_s[DVD_W-1];
	assign out_neg = neg_s[DVD_W-1];
	assign quo     = work_s[DVD_W-1];

endmodule

// ===== sv/am_waveform_sample_generator_unit.sv =====
// Top level of the AM waveform sample generator: configuration registers,
// phase front end, mixer, divider and the output clamp. Uses amwsg_pkg.
//
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  --------------------------------
// command   in         start, busy             sample_index (16 bit)
// result    out        done (one-cycle pulse)  sample_code (16 bit)
// config    in         cfg_we                  cfg_index (3 bit), cfg_data (24 bit)
//
// One item is accepted per clock while busy is low. Each result is on sample_code with done
// high once its item has passed five phase stages, seven mixer stages, 34 divider stages
// (one per quotient bit of the 34-bit dividend) and the output register. The divider
// stage count sets most of the latency; throughput stays at one item per cycle.
// Reset is asynchronous and active low. It clears all valid bits, loads the
// register defaults and holds busy high until the first clock after release.
// The result side cannot stall, so the pipeline never stops.
module am_waveform_sample_generator_unit import amwsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [INDEX_W-1:0]    sample_index,
	output logic                  done,
	output logic [CODE_W-1:0]     sample_code,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	logic                    busy_q;
	logic                    accept;
	logic [DIVISOR_W-1:0]    gain_sum;
	logic                    gain_sum_zero;

	logic                    ph_vld;
	logic signed [COS_W-1:0] cos_c;
	logic signed [COS_W-1:0] cos_m;

	logic                    mix_vld;
	logic                    mix_neg;
	logic [DVD_W-1:0]        mix_dvd;

	logic                    div_vld;
	logic                    div_neg;
	logic [DVD_W-1:0]        quo;

	logic                    done_q;
	logic [CODE_W-1:0]       code_q;
	logic [CODE_W-1:0]       code_next;
	logic [DVD_W-1:0]        lo_ext;
	logic [DVD_W:0]          sum_up;
	logic [DVD_W-1:0]        diff_dn;

	// Registers take writes directly; the datapath reads them live, which is safe only if
	// the user writes them while no item is in flight; the block does not enforce this.
	amwsg_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Busy is high only during reset and the first cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy          = busy_q;
	assign accept        = start && !busy_q;
	assign gain_sum      = {1'b0, cfg.carrier_gain} + {1'b0, cfg.modulating_gain};
	assign gain_sum_zero = (gain_sum == '0);

	amwsg_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_vld       (accept),
		.sample_index (sample_index),
		.out_vld      (ph_vld),
		.cos_c        (cos_c),
		.cos_m        (cos_m)
	);

	amwsg_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.gain_sum (gain_sum),
		.in_vld   (ph_vld),
		.cos_c    (cos_c),
		.cos_m    (cos_m),
		.out_vld  (mix_vld),
		.neg      (mix_neg),
		.dvd      (mix_dvd)
	);

	amwsg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (gain_sum),
		.in_vld  (mix_vld),
		.in_neg  (mix_neg),
		.in_dvd  (mix_dvd),
		.out_vld (div_vld),
		.out_neg (div_neg),
		.quo     (quo)
	);

	// The quotient is the magnitude of the code offset, truncated toward zero.
	// Applying it to code_low by its sign saturates at both ends of the code range; with a
	// zero total gain the code is code_low regardless of the divider.
	assign lo_ext  = {{(DVD_W-CODE_W){1'b0}}, cfg.code_low};
	assign sum_up  = {1'b0, quo} + {1'b0, lo_ext};
	assign diff_dn = lo_ext - quo;

	always_comb begin
		priority if (gain_sum_zero) begin
			code_next = cfg.code_low;
		end else if (div_neg && (quo > lo_ext)) begin
			code_next = '0;
		end else if (div_neg) begin
			code_next = diff_dn[CODE_W-1:0];
		end else if (sum_up[DVD_W:CODE_W] != '0) begin
			code_next = '1;
		end else begin
			code_next = sum_up[CODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_next;
	end

	assign done        = done_q;
	assign sample_code = code_q;

`ifndef NO_ASSERTIONS
	// Every accepted item leaves the pipeline after the fixed latency.
	a_latency_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item did not produce a result at the expected cycle");

	// No result appears without an item accepted the fixed latency earlier.
	a_latency_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a matching accepted item");

	// With zero total gain the output register must carry code_low.
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(gain_sum_zero)) |-> (sample_code == $past(cfg.code_low)))
		else $error("zero total gain did not give code_low");
`endif

endmodule
